// ===== rtl/core/mwmgk_pkg.sv =====
package mwmgk_pkg;

	// Item kinds carried on the input tuser bit.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Result of the shared key comparator.
	typedef struct packed {
		logic gt;  // stored key is strictly larger than the reference key
		logic eq;  // stored key equals the reference key
	} cmp_res_t;

endpackage

// ===== rtl/core/mwmgk_store.sv =====
module mwmgk_store #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data is registered; the same address may be written in that cycle.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/mwmgk_cmp.sv =====
module mwmgk_cmp
	import mwmgk_pkg::*;
#(
	parameter int W = 32
) (
	input  logic [W-1:0] stored_key,
	input  logic [W-1:0] ref_key,
	output cmp_res_t     res
);

	always_comb begin
		res.gt = stored_key > ref_key;
		res.eq = stored_key == ref_key;
	end

endmodule

// ===== rtl/core/multiway_merge_group_by_key.sv =====
// Multiway merge grouped by key.
// Input channel s_*: one beat is one command. s_tuser[0] selects load or pop; a load
// carries the target list, key and value in s_tdata. Output channel m_*: exactly one
// beat per command. A pop returns the largest key over all lists (ties to the lower
// list) with its value, and m_tlast marks the last pair of an equal-key group.
// m_tuser flags a pop on empty lists or a load that was dropped (full or unknown list).
// Steps: a stored load fetches its list top, then the sorted insert moves each stored
// pair with a larger key up by one place before it writes the new pair; a dropped load
// goes straight to its result. A pop reads each list top in turn from the pair memory,
// which has a single read port, and one key comparator judges them in turn; the pair
// under the popped one then helps decide m_tlast. One command is worked on at a time;
// s_tready is high only between commands and rises in the cycle after the result beat
// is loaded, so a new command is never taken before the last one is through.
// A finished result waits in the output register while the next command is already
// accepted; a command that finishes while the receiver stalls waits for that register.
// Reset clears all fill counts, so every list starts empty; the pair memory itself is
// not cleared and needs no clearing pass.
module multiway_merge_group_by_key
	import mwmgk_pkg::*;
#(
	parameter int NUM_LISTS   = 4,
	parameter int LIST_DEPTH  = 256,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // list_index[1:0], pair_key[33:2], pair_value[65:34], zero pad
	input  logic [0:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_key[31:0], out_value[63:32]
	output logic        m_tlast,   // group_last
	output logic [1:0]  m_tuser    // all_empty[0], load_dropped[1]
);

	localparam int LW = $clog2(NUM_LISTS);
	localparam int OW = $clog2(LIST_DEPTH);
	localparam int FW = $clog2(LIST_DEPTH + 1);
	localparam int TOTAL = NUM_LISTS * LIST_DEPTH;
	localparam int AW = $clog2(TOTAL);
	localparam int DW = KEY_WIDTH + VALUE_WIDTH;
	localparam logic [AW-1:0] DEPTH_A = AW'(LIST_DEPTH);
	localparam logic [FW-1:0] FILL_FULL = FW'(LIST_DEPTH);
	localparam logic [LW-1:0] LAST_LIST = LW'(NUM_LISTS - 1);

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_INS_CMP   = 8'b0000_0010,
		S_POP_SCAN  = 8'b0000_0100,
		S_POP_DRAIN = 8'b0000_1000,
		S_POP_NEXT  = 8'b0001_0000,
		S_POP_CHK   = 8'b0010_0000,
		S_DONE      = 8'b0100_0000
	} state_t;

	function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] lst,
		input logic [OW-1:0] off);
		return AW'(lst) * DEPTH_A + AW'(off);
	endfunction

	// Input beat fields.
	logic        in_cmd;
	logic [1:0]  in_list;
	logic [31:0] in_key;
	logic [31:0] in_val;
	logic        in_lst_ok;
	logic [LW-1:0] in_lst_w;

	assign in_cmd    = s_tuser[0];
	assign in_list   = s_tdata[1:0];
	assign in_key    = s_tdata[33:2];
	assign in_val    = s_tdata[65:34];
	assign in_lst_ok = 32'(in_list) < NUM_LISTS;
	assign in_lst_w  = LW'(in_list);

	state_t state_q;

	// Fill count per list; lists grow from offset zero upward, top is fill-1.
	logic [FW-1:0] fill_q [NUM_LISTS];
	logic [LW-1:0] fill_idx;
	logic [FW-1:0] fill_rd;

	// Working registers.
	logic [LW-1:0]          idx_q;      // list whose top is being read in the scan
	logic [LW-1:0]          lst_q;      // list receiving a load
	logic [OW-1:0]          p_q;        // insert position within that list
	logic [KEY_WIDTH-1:0]   key_q;      // new key on a load, best key on a pop
	logic [VALUE_WIDTH-1:0] val_q;
	logic                   found_q;
	logic                   tie_q;      // another list top equals the best key
	logic [LW-1:0]          best_q;
	logic [FW-1:0]          bfill_q;
	logic                   vld_s1;
	logic [LW-1:0]          idx_s1;
	logic [FW-1:0]          fill_s1;

	logic res_pop_q;
	logic res_last_q;
	logic res_empty_q;
	logic res_drop_q;

	logic        m_tvalid_q;
	logic [31:0] m_key_q;
	logic [31:0] m_val_q;
	logic        m_last_q;
	logic        m_empty_q;
	logic        m_drop_q;

	// Pair memory ports.
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [DW-1:0] mem_wr_data;
	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic [DW-1:0] mem_rd_data;

	logic [KEY_WIDTH-1:0]   rd_key;
	logic [VALUE_WIDTH-1:0] rd_val;
	cmp_res_t               cmp;

	logic out_free;
	logic load_drop;
	logic ins_place;

	assign rd_key = mem_rd_data[KEY_WIDTH-1:0];
	assign rd_val = mem_rd_data[DW-1:KEY_WIDTH];

	mwmgk_store #(
		.DEPTH (TOTAL),
		.WIDTH (DW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// The one comparator: the freshly read pair against the key in key_q.
	mwmgk_cmp #(
		.W (KEY_WIDTH)
	) u_cmp (
		.stored_key (rd_key),
		.ref_key    (key_q),
		.res        (cmp)
	);

	assign s_tready  = state_q == S_IDLE;
	assign out_free  = !m_tvalid_q || m_tready;
	assign load_drop = !in_lst_ok || (fill_rd == FILL_FULL);
	// The new pair goes in at p_q once the list bottom is reached or the pair below
	// is not larger; equal keys stay below, so the newest of a group pops first.
	assign ins_place = (p_q == '0) || !cmp.gt;

	// One fill count is looked at per cycle, chosen by the sequencer state.
	always_comb begin
		case (state_q)
			S_IDLE:    fill_idx = in_lst_w;
			S_INS_CMP: fill_idx = lst_q;
			default:   fill_idx = idx_q;
		endcase
		fill_rd = fill_q[fill_idx];
	end

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = addr_of(lst_q, p_q);
		mem_wr_data = {val_q, key_q};
		mem_rd_en   = 1'b0;
		mem_rd_addr = addr_of(idx_q, OW'(fill_rd - 1'b1));
		case (state_q)
			S_IDLE: begin
				// Fetch the current top of the target list as soon as the load arrives.
				mem_rd_en   = s_tvalid && (in_cmd == CMD_LOAD) && !load_drop &&
					(fill_rd != '0);
				mem_rd_addr = addr_of(in_lst_w, OW'(fill_rd - 1'b1));
			end
			S_INS_CMP: begin
				mem_wr_en = 1'b1;
				if (!ins_place) begin
					// Move the larger pair up one place and fetch the next one down.
					mem_wr_data = mem_rd_data;
					mem_rd_en   = p_q >= 2;
					mem_rd_addr = addr_of(lst_q, p_q - 1'b1 - 1'b1);
				end
			end
			S_POP_SCAN: begin
				mem_rd_en = fill_rd != '0;
			end
			S_POP_NEXT: begin
				// The pair under the popped one decides whether the group goes on.
				mem_rd_en   = found_q && (bfill_q >= FW'(2));
				mem_rd_addr = addr_of(best_q, OW'(bfill_q - FW'(2)));
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			tie_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (vld_s1) begin
				if (!found_q || cmp.gt) begin
					found_q <= 1'b1;
					tie_q   <= 1'b0;
				end else if (cmp.eq) begin
					tie_q <= 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (in_cmd == CMD_POP) begin
							state_q <= S_POP_SCAN;
							idx_q   <= '0;
							found_q <= 1'b0;
							tie_q   <= 1'b0;
							vld_s1  <= 1'b0;
						end else if (load_drop) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_INS_CMP;
						end
					end
				end
				S_INS_CMP: begin
					if (ins_place) begin
						fill_q[lst_q] <= fill_rd + 1'b1;
						state_q       <= S_DONE;
					end
				end
				S_POP_SCAN: begin
					vld_s1 <= fill_rd != '0;
					if (idx_q == LAST_LIST) begin
						state_q <= S_POP_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_POP_DRAIN: begin
					vld_s1  <= 1'b0;
					state_q <= S_POP_NEXT;
				end
				S_POP_NEXT: begin
					if (found_q) begin
						fill_q[best_q] <= bfill_q - 1'b1;
						state_q        <= (bfill_q >= FW'(2)) ? S_POP_CHK : S_DONE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_POP_CHK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (vld_s1 && (!found_q || cmp.gt)) begin
			best_q  <= idx_s1;
			bfill_q <= fill_s1;
			key_q   <= rd_key;
			val_q   <= rd_val;
		end
		case (state_q)
			S_IDLE: begin
				lst_q       <= in_lst_w;
				p_q         <= OW'(fill_rd);
				key_q       <= KEY_WIDTH'(in_key);
				val_q       <= VALUE_WIDTH'(in_val);
				res_pop_q   <= 1'b0;
				res_last_q  <= 1'b0;
				res_empty_q <= 1'b0;
				res_drop_q  <= (in_cmd == CMD_LOAD) && load_drop;
			end
			S_INS_CMP: begin
				if (!ins_place) begin
					p_q <= p_q - 1'b1;
				end
			end
			S_POP_SCAN: begin
				idx_s1  <= idx_q;
				fill_s1 <= fill_rd;
			end
			S_POP_NEXT: begin
				res_pop_q   <= found_q;
				res_empty_q <= !found_q;
				res_last_q  <= found_q && !tie_q;
			end
			S_POP_CHK: begin
				res_last_q <= !tie_q && !cmp.eq;
			end
			S_DONE: begin
				if (out_free) begin
					m_key_q   <= res_pop_q ? 32'(key_q) : '0;
					m_val_q   <= res_pop_q ? 32'(val_q) : '0;
					m_last_q  <= res_last_q;
					m_empty_q <= res_empty_q;
					m_drop_q  <= res_drop_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_val_q, m_key_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = {m_drop_q, m_empty_q};

	// A load never reaches the insert loop with its list already full.
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_CMP |-> fill_rd != FILL_FULL)
		else $error("insert started on a full list");

	// A pop that found a pair takes it from a list that holds at least one.
	a_best_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP_NEXT && found_q) |-> bfill_q != '0)
		else $error("popped list is empty");

	// At most one of the three result flags is set in a result beat.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> $onehot0({m_last_q, m_empty_q, m_drop_q}))
		else $error("conflicting result flags");

	// After a command is taken, no second one is taken in the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("command accepted while busy");

endmodule

// ===== tb/multiway_merge_group_by_key_tb.sv =====
// Scoreboard for the merge block: it keeps its own copy of the sorted lists,
// works out the beat that each accepted command must produce, and compares the
// beats seen on the output channel against those, oldest first.
class group_merge_board #(int LISTS = 4, int DEPTH = 256);

	typedef struct {
		bit [31:0] key;
		bit [31:0] value;
		bit        last;
		bit        empty;
		bit        dropped;
	} outcome_t;

	bit [31:0]   stored_key [LISTS][DEPTH];
	bit [31:0]   stored_value [LISTS][DEPTH];
	int unsigned fill [LISTS];
	outcome_t    awaited_outcomes [$];
	int          failures;

	function new();
		for (int i = 0; i < LISTS; i++) begin
			fill[i] = 0;
		end
		failures = 0;
	endfunction

	function int total_fill();
		int sum;
		sum = 0;
		for (int i = 0; i < LISTS; i++) begin
			sum += fill[i];
		end
		return sum;
	endfunction

	// Applies one accepted command to the shadow lists and queues its outcome.
	function void note_command(bit cmd, bit [1:0] idx, bit [31:0] key, bit [31:0] value);
		outcome_t    o;
		int unsigned p;
		int          best;
		bit          found;
		bit [31:0]   best_key;
		o.key = '0;
		o.value = '0;
		o.last = 1'b0;
		o.empty = 1'b0;
		o.dropped = 1'b0;
		best = 0;
		found = 1'b0;
		best_key = '0;
		if (cmd == mwmgk_pkg::CMD_POP) begin
			for (int i = 0; i < LISTS; i++) begin
				if (fill[i] != 0) begin
					if (!found || stored_key[i][fill[i] - 1] > best_key) begin
						found = 1'b1;
						best = i;
						best_key = stored_key[i][fill[i] - 1];
					end
				end
			end
			if (!found) begin
				o.empty = 1'b1;
			end else begin
				fill[best]--;
				o.key = stored_key[best][fill[best]];
				o.value = stored_value[best][fill[best]];
				o.last = 1'b1;
				// Any other pair of the same key can only sit at the top of a list.
				for (int i = 0; i < LISTS; i++) begin
					if (fill[i] != 0 && stored_key[i][fill[i] - 1] == o.key) begin
						o.last = 1'b0;
					end
				end
			end
		end else if (idx >= LISTS || fill[idx] >= DEPTH) begin
			o.dropped = 1'b1;
		end else begin
			p = fill[idx];
			// Strictly larger keys move up; an equal key stays below the new pair.
			while (p > 0 && stored_key[idx][p - 1] > key) begin
				stored_key[idx][p] = stored_key[idx][p - 1];
				stored_value[idx][p] = stored_value[idx][p - 1];
				p--;
			end
			stored_key[idx][p] = key;
			stored_value[idx][p] = value;
			fill[idx]++;
		end
		awaited_outcomes.insert(awaited_outcomes.size(), o);
	endfunction

	// Compares one output beat with the oldest outstanding outcome.
	function void check_beat(bit [31:0] key, bit [31:0] value, bit last, bit empty,
			bit dropped);
		outcome_t o;
		if (awaited_outcomes.size() == 0) begin
			$display("%0t: output beat with no command outstanding (key %h value %h)",
				$time, key, value);
			failures++;
			return;
		end
		o = awaited_outcomes.pop_front();
		if (o.key !== key) begin
			$display("%0t: out_key expected %h, got %h", $time, o.key, key);
			failures++;
		end
		if (o.value !== value) begin
			$display("%0t: out_value expected %h, got %h", $time, o.value, value);
			failures++;
		end
		if (o.last !== last) begin
			$display("%0t: group_last expected %b, got %b", $time, o.last, last);
			failures++;
		end
		if (o.empty !== empty) begin
			$display("%0t: all_empty expected %b, got %b", $time, o.empty, empty);
			failures++;
		end
		if (o.dropped !== dropped) begin
			$display("%0t: load_dropped expected %b, got %b", $time, o.dropped, dropped);
			failures++;
		end
	endfunction

endclass

module multiway_merge_group_by_key_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mwmgk_pkg::*;

	localparam int NUM_LISTS   = 4;
	localparam int LIST_DEPTH  = 256;
	// A full-depth insert moves up to LIST_DEPTH - 1 pairs, so this covers the
	// slowest command with room to spare.
	localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 50;
	// Slowest command plus the longest gap on each side, over every command,
	// taken several times over.
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int RANDOM_ITEMS = 1600;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // list_index[1:0], pair_key[33:2], pair_value[65:34], zero pad
	logic [0:0]  s_tuser;   // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // out_key[31:0], out_value[63:32]
	logic        m_tlast;   // group_last
	logic [1:0]  m_tuser;   // all_empty[0], load_dropped[1]

	int cyc = 0;
	int beats_seen;

	group_merge_board #(.LISTS(NUM_LISTS), .DEPTH(LIST_DEPTH)) board;

	multiway_merge_group_by_key #(
		.NUM_LISTS  (NUM_LISTS),
		.LIST_DEPTH (LIST_DEPTH),
		.KEY_WIDTH  (32),
		.VALUE_WIDTH(32)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#4 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// Watchdog: if the run has not ended by the limit, something hung.
	initial begin
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
		end
		$display("multiway_merge_group_by_key verification failed");
		$finish;
	end

	// Some windows of the run have no idling on either side at all.
	function automatic bit calm_window();
		return ((cyc / 3000) % 3) == 1;
	endfunction

	// Key generators: a narrow range gives many equal-key groups, the others
	// cover the full width and its extremes.
	function automatic bit [31:0] pick_key(int mode);
		case (mode)
			0: begin
				return $urandom_range(0, 7);
			end
			1: begin
				return $urandom;
			end
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hFFFF_FFFE;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: begin
				return 32'hFFFF_FFF0 + $urandom_range(0, 15);
			end
		endcase
	endfunction

	// Offers one command beat, after a random gap, and waits for it to be
	// taken. The scoreboard learns of the command at the accepting edge.
	// On return s_tvalid is still high; the next call or a drain lowers it.
	task automatic send_command(input bit cmd, input bit [1:0] idx, input bit [31:0] key,
			input bit [31:0] value);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (calm_window() || r < 60) begin
			gap = 0;
		end else if (r < 95) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(15, 50);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'b0, value, key, idx};
		do begin
			@(posedge clk);
		end while (!s_tready);
		board.note_command(cmd, idx, key, value);
	endtask

	// Stops offering and waits until every outstanding result has been seen.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (board.awaited_outcomes.size() != 0);
	endtask

	// Receiver: checks every accepted output beat and throttles m_tready.
	// Once, a long hold-off lets the block fill its output register and stall
	// the input while the sender keeps offering commands.
	initial begin
		int  stall_left;
		int  r;
		bit  held;
		stall_left = 0;
		held = 1'b0;
		beats_seen = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				board.check_beat(m_tdata[31:0], m_tdata[63:32], m_tlast, m_tuser[0],
					m_tuser[1]);
				beats_seen++;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!held && beats_seen >= 250) begin
				held = 1'b1;
				stall_left = 400;
				m_tready <= 1'b0;
			end else if (calm_window()) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_tready <= 1'b1;
				end else if (r < 97) begin
					stall_left = $urandom_range(0, 3);
					m_tready <= 1'b0;
				end else begin
					stall_left = $urandom_range(20, 60);
					m_tready <= 1'b0;
				end
			end
		end
	end

	// Main stimulus: reset, a directed opening, then random bursts of loads
	// and pops, with one phase that fills a list to the brim.
	initial begin
		int        sent;
		int        n_loads;
		int        n_pops;
		int        mode;
		int        full_list;
		bit        filled_once;
		bit [1:0]  idx;
		board = new();
		sent = 0;
		filled_once = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= CMD_LOAD;
		s_tdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A pop on lists that are all empty.
		send_command(CMD_POP, 2'd0, 32'h0, 32'h0);
		// Extreme keys and values, a tie at the top key across two lists, equal
		// keys within one list, and an insert that has to move a larger key up.
		send_command(CMD_LOAD, 2'd0, 32'h0000_0000, 32'hFFFF_FFFF);
		send_command(CMD_LOAD, 2'd1, 32'hFFFF_FFFF, 32'h0000_0000);
		send_command(CMD_LOAD, 2'd3, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
		send_command(CMD_LOAD, 2'd2, 32'd5, 32'h0000_0001);
		send_command(CMD_LOAD, 2'd2, 32'd5, 32'h0000_0002);
		send_command(CMD_LOAD, 2'd3, 32'd5, 32'h0000_0003);
		send_command(CMD_LOAD, 2'd1, 32'd5, 32'h5555_5555);
		repeat (8) send_command(CMD_POP, 2'($urandom), $urandom, $urandom);
		// Inserts into the middle of a list.
		send_command(CMD_LOAD, 2'd0, 32'd9, 32'h0000_0009);
		send_command(CMD_LOAD, 2'd0, 32'd3, 32'h0000_0003);
		send_command(CMD_LOAD, 2'd0, 32'd7, 32'h0000_0007);
		repeat (4) send_command(CMD_POP, 2'($urandom), $urandom, $urandom);

		// The sender pauses here until the block has answered everything.
		wait_drained();

		while (sent < RANDOM_ITEMS) begin
			if (!filled_once && sent >= 700) begin
				// Fill one list completely, overflow it, then empty everything.
				filled_once = 1'b1;
				wait_drained();
				full_list = $urandom_range(0, NUM_LISTS - 1);
				while (board.fill[full_list] < LIST_DEPTH) begin
					send_command(CMD_LOAD, 2'(full_list), $urandom_range(0, 63), $urandom);
					sent++;
				end
				send_command(CMD_LOAD, 2'(full_list), 32'hFFFF_FFFF, $urandom);
				send_command(CMD_LOAD, 2'(full_list), 32'h0000_0000, $urandom);
				send_command(CMD_LOAD, 2'(full_list), $urandom, $urandom);
				send_command(CMD_LOAD, 2'(full_list) ^ 2'd1, 32'd17, $urandom);
				sent += 4;
				while (board.total_fill() > 0) begin
					send_command(CMD_POP, 2'($urandom), $urandom, $urandom);
					sent++;
				end
				send_command(CMD_POP, 2'($urandom), $urandom, $urandom);
				sent++;
			end else if ($urandom_range(0, 9) == 0) begin
				// Noise: a command of any kind with any content.
				send_command(1'($urandom), 2'($urandom), $urandom, $urandom);
				sent++;
			end else begin
				// A burst of loads followed by roughly as many pops; a pop now and
				// then runs past the end and finds all lists empty.
				mode = $urandom_range(0, 3);
				n_loads = $urandom_range(1, 10);
				for (int i = 0; i < n_loads; i++) begin
					idx = 2'($urandom);
					send_command(CMD_LOAD, idx, pick_key(mode), $urandom);
				end
				sent += n_loads;
				if (board.total_fill() > 150) begin
					n_pops = n_loads + 8;
				end else begin
					n_pops = $urandom_range((n_loads > 2) ? n_loads - 2 : 0, n_loads + 2);
				end
				for (int i = 0; i < n_pops; i++) begin
					send_command(CMD_POP, 2'($urandom), $urandom, $urandom);
				end
				sent += n_pops;
			end
		end

		wait_drained();
		// Give a stray extra beat the time to show up.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.failures == 0 && board.awaited_outcomes.size() == 0) begin
			$display("multiway_merge_group_by_key verification clean");
		end else begin
			$display("multiway_merge_group_by_key verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/mwmgk_pkg.sv
rtl/core/mwmgk_store.sv
rtl/core/mwmgk_cmp.sv
rtl/core/multiway_merge_group_by_key.sv
tb/multiway_merge_group_by_key_tb.sv
